FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/rac_pkg.sv
// shared constants and types of the antisymmetry checker
`timescale 1ns / 1ps
package rac_pkg;

  localparam int MAX_SIZE    = 32;
  localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int IDX_W       = $clog2(MAX_SIZE);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = ADDR_W + 1;
  localparam int N_W         = IDX_W + 1;
  localparam int SIZE_W      = 6;
  localparam int CMP_W       = (SIZE_W > N_W) ? SIZE_W : N_W;
  localparam int PROD_W      = IDX_W + N_W;
  localparam int CODE_W      = 2;
  localparam int TDATA_W     = 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // register word indexes
  localparam logic [CFG_AW-3:0] REG_MATRIX_SIZE = '0;

  // entry codes
  localparam logic [CODE_W-1:0] CODE_FALSE   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 2'd2;

  // verdict codes
  localparam logic [CODE_W-1:0] VERDICT_TRUE    = 2'd0;
  localparam logic [CODE_W-1:0] VERDICT_FALSE   = 2'd1;
  localparam logic [CODE_W-1:0] VERDICT_UNKNOWN = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD_A = 5'b00010,
    ST_RD_B = 5'b00100,
    ST_EVAL = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

FILE: design/relation_antisymmetry_check_top.sv
// top level of the three-valued relation antisymmetry checker
//
// in_* stream: one matrix entry per word, column-major, in_tlast on the final
// entry. Entries load one per cycle while the block is idle into a store of
// MAX_SIZE*MAX_SIZE cells; entries past a full store are dropped. After the last
// entry the block walks pairs i<j through one shared store read port and one
// address unit (row + col*n), in three steps per pair: read a, read b, evaluate.
// A check stops early at the first deciding pair; in_tready is low meanwhile.
// out_* stream: one verdict word per last entry (0 true, 1 false, 2 unknown),
// held in an output register; loading of the next matrix goes on while it
// waits. If the receiver still stalls when the next check ends, the block
// holds that result and stays not ready until the register frees.
// cfg_* port: apb-style, register matrix_size at address 0, pready always high;
// write it only while idle. Sizes above MAX_SIZE saturate.
// rst_n (synchronous) empties the output, sets the load position to zero and
// matrix_size to 32; store contents are undefined until written.
`timescale 1ns / 1ps
module relation_antisymmetry_check_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rac_pkg::TDATA_W-1:0]   in_tdata,   // [1:0] entry_value
  input  logic                          in_tlast,   // last_entry
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rac_pkg::TDATA_W-1:0]   out_tdata,  // [1:0] verdict
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rac_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [rac_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [rac_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import rac_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [CODE_W-1:0]   a_r, a_nxt;
  logic [CODE_W-1:0]   result_r, result_nxt;
  logic [CODE_W-1:0]   verdict_r, verdict_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc, cfg_wr, sel_reg0;
  logic [CMP_W-1:0]    size_ext, n_cmp;
  logic [N_W-1:0]      n_sat;
  logic [IDX_W-1:0]    row, col;
  logic [PROD_W-1:0]   addr_full;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CODE_W-1:0]   rd_data;
  logic                ram_we;
  logic                a_unk, b_unk, a_nz, b_nz, pair_unk, pair_false;
  logic                j_end, i_end;

  assign cfg_pready = 1'b1;
  assign sel_reg0   = (cfg_paddr[CFG_AW-1:2] == REG_MATRIX_SIZE);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = sel_reg0 ? CFG_DW'(size_r) : '0;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(verdict_r);

  // saturate size to the store geometry
  assign size_ext = CMP_W'(size_r);
  assign n_cmp    = (size_ext > CMP_W'(MAX_SIZE)) ? CMP_W'(MAX_SIZE) : size_ext;
  assign n_sat    = N_W'(n_cmp);

  // shared address unit: a at (row j, col i), b at (row i, col j)
  always_comb begin
    if (state_r == ST_RD_A) begin
      row = j_r;
      col = i_r;
    end else begin
      row = i_r;
      col = j_r;
    end
  end
  assign addr_full = PROD_W'(row) + PROD_W'(col) * PROD_W'(n_sat);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  assign ram_we = in_acc & ~pos_r[POS_W-1];

  rac_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[ADDR_W-1:0]),
    .wdata (in_tdata[CODE_W-1:0]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // pair evaluation, code three counts as true
  assign a_unk      = (a_r == CODE_UNKNOWN);
  assign b_unk      = (rd_data == CODE_UNKNOWN);
  assign a_nz       = (a_r != CODE_FALSE);
  assign b_nz       = (rd_data != CODE_FALSE);
  assign pair_unk   = (a_unk & b_nz) | (b_unk & a_nz);
  assign pair_false = a_r[0] & rd_data[0];

  assign j_end = (N_W'(j_r) == n_sat - N_W'(1));
  assign i_end = (N_W'(i_r) == n_sat - N_W'(2));

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    result_nxt    = result_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    if (cfg_wr && sel_reg0) begin
      size_nxt = cfg_pwdata[SIZE_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!pos_r[POS_W-1]) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          if (in_tlast) begin
            pos_nxt = '0;
            i_nxt   = '0;
            j_nxt   = IDX_W'(1);
            if (n_sat < N_W'(2)) begin
              result_nxt = VERDICT_TRUE;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A: begin
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        a_nxt     = rd_data;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (pair_unk) begin
          result_nxt = VERDICT_UNKNOWN;
          state_nxt  = ST_DONE;
        end else if (pair_false) begin
          result_nxt = VERDICT_FALSE;
          state_nxt  = ST_DONE;
        end else if (j_end) begin
          if (i_end) begin
            result_nxt = VERDICT_TRUE;
            state_nxt  = ST_DONE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            j_nxt     = i_r + IDX_W'(2);
            state_nxt = ST_RD_A;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_RD_A;
        end
      end
      ST_DONE: begin
        // wait for the output register to free
        if (!out_valid_r || out_tready) begin
          verdict_nxt   = result_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    a_r       <= a_nxt;
    result_r  <= result_nxt;
    verdict_r <= verdict_nxt;
  end

endmodule

FILE: design/rac_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module rac_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/rac_checker.sv
// port-level checker for the antisymmetry checker, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rac_pkg::TDATA_W-1:0] out_tdata
);
  import rac_pkg::*;

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // verdict is a defined code with zero padding
  `ASSERT_IMP(a_verdict_code, out_tvalid, out_tdata[TDATA_W-1:2] == '0 && out_tdata[1:0] != 2'd3)

  // the check starts right after a last word and the block goes busy
  `ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready)

  // a result only appears at the end of a check, never straight from loading
  `ASSERT_IMP(a_result_from_check, $rose(out_tvalid), $past(!in_tready))

endmodule

bind relation_antisymmetry_check_top rac_checker u_rac_checker (.*);

FILE: tb/tb_relation_antisymmetry_check_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the relation antisymmetry checker with random matrices and stalls
module tb_relation_antisymmetry_check_top;
  import rac_pkg::*;

  localparam logic [CODE_W-1:0] CODE_TRUE     = 2'd1;
  localparam logic [CODE_W-1:0] CODE_ALT_TRUE = 2'd3;  // code three reads as true
  localparam int unsigned ENTRY_TARGET  = 1850;
  localparam int unsigned CYCLE_LIMIT   = 20000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned MAX_WAIT      = 19;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } entry_word_t;

  typedef enum logic [1:0] {
    MIX_NOISE,
    MIX_CLEAN,
    MIX_ONE_HIT
  } mix_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata    = '0;
  logic               in_tlast    = 1'b0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr   = '0;
  logic [CFG_DW-1:0]  cfg_pwdata  = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // predictor state
  logic [CODE_W-1:0] rel_cells [STORE_DEPTH];
  int unsigned       fill_pos     = 0;
  logic [SIZE_W-1:0] size_setting = SIZE_RESET;

  entry_word_t       entry_q   [$];
  logic [CODE_W-1:0] verdict_q [$];
  entry_word_t       cur_word;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned matrices = 0;
  int unsigned verdict_tally [4] = '{0, 0, 0, 0};
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_wait = 0;
  int unsigned out_draw;

  relation_antisymmetry_check_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // first deciding pair over i<j wins, else antisymmetric
  function automatic logic [CODE_W-1:0] antisym_verdict();
    int unsigned       n;
    int unsigned       i;
    int unsigned       j;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    n = (size_setting > MAX_SIZE) ? MAX_SIZE : size_setting;
    for (i = 0; i + 1 < n; i++) begin
      for (j = i + 1; j < n; j++) begin
        a = rel_cells[j + i * n];
        b = rel_cells[i + j * n];
        if (a == CODE_UNKNOWN && b != CODE_FALSE) return VERDICT_UNKNOWN;
        if (b == CODE_UNKNOWN && a != CODE_FALSE) return VERDICT_UNKNOWN;
        if (a != CODE_FALSE && b != CODE_FALSE) return VERDICT_FALSE;
      end
    end
    return VERDICT_TRUE;
  endfunction

  // 2x2 cases packed {d1, b, a, d0}, a at row 1 col 0, b at row 0 col 1
  function automatic logic [4*CODE_W-1:0] two_by_two(input int unsigned idx);
    case (idx)
      0: return {CODE_ALT_TRUE, CODE_UNKNOWN, CODE_TRUE, CODE_FALSE};
      1: return {CODE_FALSE, CODE_UNKNOWN, CODE_UNKNOWN, CODE_TRUE};
      2: return {CODE_UNKNOWN, CODE_TRUE, CODE_TRUE, CODE_ALT_TRUE};
      3: return {CODE_TRUE, CODE_TRUE, CODE_ALT_TRUE, CODE_UNKNOWN};
      4: return {CODE_ALT_TRUE, CODE_UNKNOWN, CODE_FALSE, CODE_ALT_TRUE};
      default: return {CODE_UNKNOWN, CODE_FALSE, CODE_FALSE, CODE_UNKNOWN};
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("cycle %0d: %s", cycles, what);
  endtask

  // queue one matrix of n_words words, column-major, last flag on the final word
  task automatic queue_matrix(input int unsigned n, input int unsigned n_words,
                              input mix_t mix);
    logic [CODE_W-1:0] cells [STORE_DEPTH];
    int unsigned       i;
    int unsigned       j;
    int unsigned       k;
    int unsigned       hit_i;
    int unsigned       hit_j;
    entry_word_t       w;
    for (k = 0; k < n * n; k++) cells[k] = CODE_W'($urandom_range(0, 3));
    if (mix != MIX_NOISE) begin
      // one side of every pair false keeps the walk undecided
      for (i = 0; i + 1 < n; i++) begin
        for (j = i + 1; j < n; j++) begin
          if ($urandom_range(0, 1) != 0) cells[j + i * n] = CODE_FALSE;
          else cells[i + j * n] = CODE_FALSE;
        end
      end
      if (mix == MIX_ONE_HIT && n > 1) begin
        hit_i = $urandom_range(0, n - 2);
        hit_j = $urandom_range(hit_i + 1, n - 1);
        cells[hit_j + hit_i * n] = CODE_W'($urandom_range(1, 3));
        cells[hit_i + hit_j * n] = CODE_W'($urandom_range(1, 3));
      end
    end
    for (k = 0; k < n_words; k++) begin
      w.code = (k < n * n) ? cells[k] : CODE_W'($urandom_range(0, 3));
      w.last = (k == n_words - 1);
      entry_q.push_back(w);
    end
    matrices++;
  endtask

  // sender holds off until everything queued is accepted and every verdict is back
  task automatic wait_idle(input bit settle);
    while (entry_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_MATRIX_SIZE, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    size_setting = value;
    @(negedge clk);
  endtask

  // word source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tlast  <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (entry_q.size() != 0) begin
        cur_word = entry_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= TDATA_W'(cur_word.code);
        in_tlast  <= cur_word.last;
        in_gap    <= draw_wait(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // verdict sink with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else if (out_wait != 0) begin
      out_tready <= 1'b0;
      out_wait   <= out_wait - 1;
    end else if (out_tvalid && out_tready) begin
      out_draw = draw_wait(out_calm);
      out_tready <= (out_draw == 0);
      out_wait   <= (out_draw == 0) ? 0 : out_draw - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // predictor and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_pos = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (fill_pos < STORE_DEPTH) begin
          rel_cells[fill_pos] = in_tdata[CODE_W-1:0];
          fill_pos++;
        end
        if (in_tlast) begin
          verdict_q.push_back(antisym_verdict());
          fill_pos = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none pending", out_tdata[CODE_W-1:0]));
        end else begin
          if (out_tdata[CODE_W-1:0] !== verdict_q[0])
            report_mismatch($sformatf("verdict %0d, predicted %0d",
                                      out_tdata[CODE_W-1:0], verdict_q[0]));
          verdict_tally[verdict_q[0]]++;
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       idx;
    int unsigned       k;
    int unsigned       pick;
    int unsigned       n;
    int unsigned       n_words;
    int unsigned       runs;
    logic [SIZE_W-1:0] size_pick;
    logic [4*CODE_W-1:0] cells4;
    entry_word_t       w;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // whole store at the reset size plus words past the end, which get dropped
    queue_matrix(MAX_SIZE, STORE_DEPTH + 6, MIX_CLEAN);
    sent += STORE_DEPTH + 6;

    wait_idle(1'b1);
    write_size(SIZE_W'(2));
    for (idx = 0; idx < 6; idx++) begin
      cells4 = two_by_two(idx);
      for (k = 0; k < 4; k++) begin
        w.code = cells4[k*CODE_W +: CODE_W];
        w.last = (k == 3);
        entry_q.push_back(w);
      end
      matrices++;
      sent += 4;
    end
    wait_idle(1'b1);
    write_size(SIZE_W'(0));
    queue_matrix(0, 3, MIX_NOISE);
    wait_idle(1'b1);
    write_size(SIZE_W'(1));
    queue_matrix(1, 1, MIX_NOISE);
    wait_idle(1'b1);
    write_size(SIZE_W'(63));
    queue_matrix(MAX_SIZE, 2, MIX_NOISE);
    sent += 6;

    while (sent < ENTRY_TARGET) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0: size_pick = SIZE_W'(0);
        1: size_pick = SIZE_W'(1);
        2: size_pick = SIZE_W'(MAX_SIZE);
        3: size_pick = SIZE_W'($urandom_range(MAX_SIZE + 1, 63));
        4: size_pick = SIZE_W'($urandom_range(9, 12));
        default: size_pick = SIZE_W'($urandom_range(2, 8));
      endcase
      wait_idle(1'b1);
      write_size(size_pick);
      n = (size_pick > MAX_SIZE) ? MAX_SIZE : size_pick;
      runs = (n > 8) ? 1 : $urandom_range(2, 6);
      repeat (runs) begin
        if (sent >= ENTRY_TARGET) break;
        // large sizes reuse stored cells, so a few words are enough
        if (n >= MAX_SIZE) n_words = $urandom_range(1, 8);
        else if (n == 0) n_words = $urandom_range(1, 4);
        else if ($urandom_range(0, 3) != 0) n_words = n * n;
        else n_words = $urandom_range(1, n * n + 6);
        in_calm  <= ($urandom_range(0, 3) == 0);
        out_calm <= ($urandom_range(0, 3) == 0);
        queue_matrix(n, n_words, mix_t'($urandom_range(0, 2)));
        sent += n_words;
        if ($urandom_range(0, 5) == 0) wait_idle(1'b0);
        else while (entry_q.size() != 0) @(negedge clk);
      end
    end

    wait_idle(1'b0);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d entries in %0d matrices, sizes 0 to 63, one overfilled store",
             sent, matrices);
    $display("verdicts checked: %0d true, %0d false, %0d unknown",
             verdict_tally[VERDICT_TRUE], verdict_tally[VERDICT_FALSE],
             verdict_tally[VERDICT_UNKNOWN]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
